### rtl/core/cidat_pkg.sv
// ----------------------------------------------------------------------------
// cidat_pkg: shared types and codes for the card id allowlist table
// beat layouts, command and status codes, sequencer state encoding
// ----------------------------------------------------------------------------
`default_nettype none

package cidat_pkg;

   // default table depth
   localparam int CAPACITY_DEFAULT = 64;

   // command codes
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_PRESENT = 2'd1,
      STAT_ABSENT  = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_SHIFT  = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   // request beat
   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] card_id;
   } req_type;

   // response beat
   typedef struct packed {
      logic        found;
      logic [5:0]  slot;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/card_id_allowlist_table.sv
// Search: ids are read in slot order until the first hit shows in the registered read data
// or all stored entries are read; a delete that is not the last entry then compacts the entries
// behind it down one slot, and a response beat is held until it is taken.
// One command at a time: the next command is taken in the idle state after the response;
// one table read and one write per cycle bound the walk.
// Reset: synchronous, clears the entry count and the sequencer; table contents are kept.
// ----------------------------------------------------------------------------
// card_id_allowlist_table: ordered allowlist of 32-bit card ids
// lookup, insert if absent, delete with compaction and clear, one entry per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module card_id_allowlist_table
   import cidat_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // table memory and registered read port
   logic [31:0]      mem [CAPACITY];
   logic [31:0]      rd_data_ff;
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;

   // sequencer and command state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] hit_ff, hit_in;
   logic             found_ff, found_in;
   status_type       status_ff, status_in;
   logic [31:0]      id_ff;
   op_type           op_ff;

   logic             match;
   logic             more;
   logic             accept;

   assign accept = req_valid && !req_stall;

   // compare of the entry read last cycle; a zero low byte never matches
   assign match = cmp_vld_ff && (rd_data_ff == id_ff) && (id_ff[7:0] != 8'd0);
   assign more  = ptr_ff < count_ff;

   // memory access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   // captured command
   always_ff @(posedge clock) begin
      if (accept) begin
         id_ff <= req_data.card_id;
         op_ff <= op_type'(req_data.opcode);
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = cmp_vld_ff;
      hit_in     = hit_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = id_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in   = ST_SEARCH;
               ptr_in     = '0;
               cmp_vld_in = 1'b0;
            end
         end

         ST_SEARCH: begin
            if (!match && more) begin
               // issue the next read
               rd_en      = 1'b1;
               ptr_in     = CNT_W'(ptr_ff + 1'b1);
               cmp_idx_in = ptr_ff[IDX_W-1:0];
               cmp_vld_in = 1'b1;
            end else begin
               // search resolved: act on the command
               found_in   = match;
               hit_in     = match ? cmp_idx_ff : '0;
               cmp_vld_in = 1'b0;
               state_in   = ST_RESP;
               case (op_ff)
                  OP_LOOKUP: begin
                     status_in = match ? STAT_DONE : STAT_ABSENT;
                  end
                  OP_INSERT: begin
                     if (match) begin
                        status_in = STAT_PRESENT;
                     end else if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = CNT_W'(count_ff + 1'b1);
                        status_in = STAT_DONE;
                     end
                  end
                  OP_DELETE: begin
                     if (!match) begin
                        status_in = STAT_ABSENT;
                     end else begin
                        status_in = STAT_DONE;
                        if (CNT_W'(CNT_W'(cmp_idx_ff) + 1'b1) < count_ff) begin
                           state_in = ST_SHIFT;
                           ptr_in   = CNT_W'(CNT_W'(cmp_idx_ff) + 1'b1);
                        end else begin
                           count_in = CNT_W'(count_ff - 1'b1);
                        end
                     end
                  end
                  default: begin
                     count_in  = '0;
                     status_in = STAT_DONE;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            // move the entry read last cycle down one slot
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(cmp_idx_ff - 1'b1);
               wr_data = rd_data_ff;
            end
            if (more) begin
               rd_en      = 1'b1;
               ptr_in     = CNT_W'(ptr_ff + 1'b1);
               cmp_idx_in = ptr_ff[IDX_W-1:0];
               cmp_vld_in = 1'b1;
            end else begin
               cmp_vld_in = 1'b0;
               count_in   = CNT_W'(count_ff - 1'b1);
               state_in   = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   // walk and result registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      status_ff  <= status_in;
   end

   // handshake and response beat
   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_RESP);
   assign rsp_data.found       = found_ff;
   assign rsp_data.slot        = 6'(hit_ff);
   assign rsp_data.status      = status_ff;
   assign rsp_data.entry_count = 7'(count_ff);

   // entry count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   // no new command while a response beat is pending
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   // writes land only inside or at the end of the stored entries
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CNT_W'(wr_addr) <= count_ff))
      else $error("table write beyond entry count");

   // a response on a miss reports slot zero
   a_slot_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.slot == 6'd0))
      else $error("nonzero slot on a miss");

endmodule

`default_nettype wire
